// ----- src/abrq_pkg.sv -----
package abrq_pkg;

  localparam int unsigned QUEUE_BLOCKS = 16;
  localparam int unsigned BLOCK_FRAMES = 64;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DROP_W   = 32;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_SAMPLE    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_CAP_SMALL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_WR_SAMPLE,
    CMD_WR_LAST,
    CMD_RD_BLOCK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [SAMPLE_W-1:0]   sample;
    logic [STAMP_W-1:0]    stamp;
    logic [CAP_W-1:0]      cap;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

// ----- src/abrq_front.sv -----
module abrq_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             op_i,
  input  logic [abrq_pkg::SAMPLE_W-1:0]    sample_bits_i,
  input  logic                             block_end_i,
  input  logic [abrq_pkg::STAMP_W-1:0]     stamp_i,
  input  logic [abrq_pkg::CAP_W-1:0]       read_capacity_i,
  output abrq_pkg::cmd_slot_t              head_o,
  input  logic                             pop_i
);

  abrq_pkg::cmd_t                     fifo_q [abrq_pkg::CMD_DEPTH];
  logic [abrq_pkg::CMD_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [abrq_pkg::CMD_CNT_W-1:0]     cnt_q, cnt_d;
  abrq_pkg::cmd_t                     cmd_in;
  logic                               push;

  // classify the incoming item
  always_comb begin
    cmd_in.sample = sample_bits_i;
    cmd_in.stamp  = stamp_i;
    cmd_in.cap    = read_capacity_i;
    if (op_i) begin
      cmd_in.kind = abrq_pkg::CMD_RD_BLOCK;
    end else if (block_end_i) begin
      cmd_in.kind = abrq_pkg::CMD_WR_LAST;
    end else begin
      cmd_in.kind = abrq_pkg::CMD_WR_SAMPLE;
    end
  end

  assign busy_o = (cnt_q == abrq_pkg::CMD_CNT_W'(abrq_pkg::CMD_DEPTH));
  assign push   = start_i && !busy_o;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == abrq_pkg::CMD_PTR_W'(abrq_pkg::CMD_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == abrq_pkg::CMD_PTR_W'(abrq_pkg::CMD_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid) else $error("pop from empty command queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= abrq_pkg::CMD_CNT_W'(abrq_pkg::CMD_DEPTH))
    else $error("command queue count overflow");

endmodule

// ----- src/abrq_back.sv -----
module abrq_back #(
  parameter int unsigned QUEUE_BLOCKS = abrq_pkg::QUEUE_BLOCKS,
  parameter int unsigned BLOCK_FRAMES = abrq_pkg::BLOCK_FRAMES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  abrq_pkg::cmd_slot_t              head_i,
  output logic                             pop_o,
  output logic                             valid_o,
  output logic [abrq_pkg::STATUS_W-1:0]    status_o,
  output logic [abrq_pkg::SAMPLE_W-1:0]    out_sample_o,
  output logic                             out_last_o,
  output logic [abrq_pkg::STAMP_W-1:0]     out_stamp_o,
  output logic [abrq_pkg::COUNT_W-1:0]     out_count_o,
  output logic [abrq_pkg::DROP_W-1:0]      drop_total_o
);

  localparam int unsigned PW    = $clog2(2 * QUEUE_BLOCKS);
  localparam int unsigned SW    = $clog2(QUEUE_BLOCKS);
  localparam int unsigned AW    = $clog2(QUEUE_BLOCKS * BLOCK_FRAMES);
  localparam int unsigned FW    = $clog2(BLOCK_FRAMES + 2);
  localparam int unsigned CW    = $clog2(BLOCK_FRAMES + 1);
  localparam int unsigned DEPTH = QUEUE_BLOCKS * BLOCK_FRAMES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_STREAM
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STORE,
    MODE_DISCARD,
    MODE_REJECT
  } mode_e;

  // block memories
  logic [abrq_pkg::SAMPLE_W-1:0] sample_mem [DEPTH];
  logic [abrq_pkg::STAMP_W-1:0]  stamp_mem  [QUEUE_BLOCKS];
  logic [CW-1:0]                 count_mem  [QUEUE_BLOCKS];
  logic [abrq_pkg::SAMPLE_W-1:0] smp_rd_q;
  logic [abrq_pkg::STAMP_W-1:0]  stp_rd_q;
  logic [CW-1:0]                 cnt_rd_q;

  state_e                        state_q, state_d;
  mode_e                         mode_q, mode_d, mode_w;
  logic [PW-1:0]                 head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]                 fill_q, fill_d, fill_w;
  logic [abrq_pkg::DROP_W-1:0]   drop_q, drop_d;
  logic [CW-1:0]                 idx_q, idx_d, rd_idx;
  logic [abrq_pkg::CAP_W-1:0]    cap_q, cap_d;

  logic                          valid_d, last_d;
  abrq_pkg::status_e             status_d;
  logic [abrq_pkg::SAMPLE_W-1:0] sample_d;
  logic [abrq_pkg::STAMP_W-1:0]  stamp_d;
  logic [abrq_pkg::COUNT_W-1:0]  count_d;

  logic [SW-1:0]                 head_slot, tail_slot;
  logic [PW:0]                   used;
  logic                          full, empty, is_end;
  logic                          smp_we, blk_we;
  logic [AW-1:0]                 wr_addr, rd_addr;

  assign head_slot = SW'((head_q >= PW'(QUEUE_BLOCKS)) ? head_q - PW'(QUEUE_BLOCKS) : head_q);
  assign tail_slot = SW'((tail_q >= PW'(QUEUE_BLOCKS)) ? tail_q - PW'(QUEUE_BLOCKS) : tail_q);
  assign used      = (head_q >= tail_q) ?
                     (PW+1)'(head_q) - (PW+1)'(tail_q) :
                     (PW+1)'(head_q) + (PW+1)'(2 * QUEUE_BLOCKS) - (PW+1)'(tail_q);
  assign full      = (used >= (PW+1)'(QUEUE_BLOCKS));
  assign empty     = (head_q == tail_q);
  assign is_end    = (head_i.cmd.kind == abrq_pkg::CMD_WR_LAST);

  assign wr_addr = AW'(head_slot) * AW'(BLOCK_FRAMES) + AW'(fill_w - 1'b1);
  assign rd_addr = AW'(tail_slot) * AW'(BLOCK_FRAMES) + AW'(rd_idx);

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    idx_d    = idx_q;
    cap_d    = cap_q;
    pop_o    = 1'b0;
    smp_we   = 1'b0;
    blk_we   = 1'b0;
    rd_idx   = '0;
    mode_w   = mode_q;
    fill_w   = fill_q;
    valid_d  = 1'b0;
    status_d = abrq_pkg::ST_WRITTEN;
    sample_d = '0;
    last_d   = 1'b0;
    stamp_d  = '0;
    count_d  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.cmd.kind == abrq_pkg::CMD_RD_BLOCK) begin
            if (empty) begin
              valid_d  = 1'b1;
              status_d = abrq_pkg::ST_EMPTY;
            end else begin
              cap_d   = head_i.cmd.cap;
              state_d = S_CHECK;
            end
          end else begin
            // fullness is judged at the first sample of a block
            if (mode_q == MODE_IDLE) begin
              fill_w = '0;
              mode_w = full ? MODE_DISCARD : MODE_STORE;
            end
            if (fill_w < FW'(BLOCK_FRAMES + 1)) begin
              fill_w = fill_w + 1'b1;
            end
            if (fill_w > FW'(BLOCK_FRAMES)) begin
              mode_w = MODE_REJECT;
            end
            valid_d = 1'b1;
            unique case (mode_w)
              MODE_STORE: begin
                status_d = abrq_pkg::ST_WRITTEN;
                smp_we   = 1'b1;
                if (is_end) begin
                  blk_we = 1'b1;
                  head_d = (head_q == PW'(2 * QUEUE_BLOCKS - 1)) ? '0 : head_q + 1'b1;
                end
              end
              MODE_DISCARD: begin
                status_d = abrq_pkg::ST_DROPPED;
                if (is_end) begin
                  drop_d = drop_q + 1'b1;
                end
              end
              default: begin
                status_d = abrq_pkg::ST_TOO_LONG;
              end
            endcase
            mode_d = is_end ? MODE_IDLE : mode_w;
            fill_d = is_end ? '0 : fill_w;
          end
        end
      end
      S_CHECK: begin
        if (cap_q < abrq_pkg::CAP_W'(cnt_rd_q)) begin
          valid_d  = 1'b1;
          status_d = abrq_pkg::ST_CAP_SMALL;
          count_d  = abrq_pkg::COUNT_W'(cnt_rd_q);
          state_d  = S_IDLE;
        end else begin
          idx_d   = '0;
          rd_idx  = '0;
          state_d = S_STREAM;
        end
      end
      S_STREAM: begin
        valid_d  = 1'b1;
        status_d = abrq_pkg::ST_SAMPLE;
        sample_d = smp_rd_q;
        stamp_d  = stp_rd_q;
        count_d  = abrq_pkg::COUNT_W'(cnt_rd_q);
        if (idx_q == cnt_rd_q - 1'b1) begin
          last_d  = 1'b1;
          tail_d  = (tail_q == PW'(2 * QUEUE_BLOCKS - 1)) ? '0 : tail_q + 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d  = idx_q + 1'b1;
          rd_idx = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      drop_q       <= '0;
      idx_q        <= '0;
      cap_q        <= '0;
      valid_o      <= 1'b0;
      status_o     <= '0;
      out_sample_o <= '0;
      out_last_o   <= 1'b0;
      out_stamp_o  <= '0;
      out_count_o  <= '0;
      drop_total_o <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      drop_q       <= drop_d;
      idx_q        <= idx_d;
      cap_q        <= cap_d;
      valid_o      <= valid_d;
      status_o     <= status_d;
      out_sample_o <= sample_d;
      out_last_o   <= last_d;
      out_stamp_o  <= stamp_d;
      out_count_o  <= count_d;
      drop_total_o <= drop_d;
    end
  end

  // one write and one read port on the sample store
  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      sample_mem[wr_addr] <= head_i.cmd.sample;
    end
    smp_rd_q <= sample_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      stamp_mem[head_slot] <= head_i.cmd.stamp;
      count_mem[head_slot] <= CW'(fill_w);
    end
    stp_rd_q <= stamp_mem[tail_slot];
    cnt_rd_q <= count_mem[tail_slot];
  end

  a_last_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o |-> (valid_o && status_o == abrq_pkg::ST_SAMPLE))
    else $error("last flag outside a sample transfer");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BLOCK_FRAMES + 1)) else $error("fill count out of range");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= (PW+1)'(QUEUE_BLOCKS)) else $error("queue holds more than its blocks");

  a_stream_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pop_o) else $error("command taken during read");

endmodule

// ----- src/audio_block_ring_queue.sv -----
// Channel   Direction  Handshake           Payload
// command   in         start_i / busy_o    op_i, sample_bits_i, block_end_i, stamp_i,
//                                          read_capacity_i
// result    out        valid_o (strobe)    status_o, out_sample_o, out_last_o,
//                                          out_stamp_o, out_count_o, drop_total_o
//
// A command transfers on an edge with start_i high and busy_o low, into a two-entry
// command queue; the back end takes one command per cycle while idle.
// Back end steps: a write and an empty read give a registered result from the take; a read
// with too small a capacity goes through S_CHECK; any other read: take, header, samples.
// Results cannot be stalled; busy_o rises only while the queue is full behind a read.
// Reset clears pointers, drop count, open block and command queue, not the block stores.
module audio_block_ring_queue #(
  parameter int unsigned QUEUE_BLOCKS = abrq_pkg::QUEUE_BLOCKS,
  parameter int unsigned BLOCK_FRAMES = abrq_pkg::BLOCK_FRAMES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             op_i,
  input  logic [abrq_pkg::SAMPLE_W-1:0]    sample_bits_i,
  input  logic                             block_end_i,
  input  logic [abrq_pkg::STAMP_W-1:0]     stamp_i,
  input  logic [abrq_pkg::CAP_W-1:0]       read_capacity_i,
  output logic                             valid_o,
  output logic [abrq_pkg::STATUS_W-1:0]    status_o,
  output logic [abrq_pkg::SAMPLE_W-1:0]    out_sample_o,
  output logic                             out_last_o,
  output logic [abrq_pkg::STAMP_W-1:0]     out_stamp_o,
  output logic [abrq_pkg::COUNT_W-1:0]     out_count_o,
  output logic [abrq_pkg::DROP_W-1:0]      drop_total_o
);

  // head entry of the command queue and the back end's take signal
  abrq_pkg::cmd_slot_t head;
  logic                pop;

  abrq_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .sample_bits_i,
    .block_end_i,
    .stamp_i,
    .read_capacity_i,
    .head_o (head),
    .pop_i  (pop)
  );

  // back end: block writer, reader sequencer and the block stores
  abrq_back #(
    .QUEUE_BLOCKS (QUEUE_BLOCKS),
    .BLOCK_FRAMES (BLOCK_FRAMES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head),
    .pop_o        (pop),
    .valid_o,
    .status_o,
    .out_sample_o,
    .out_last_o,
    .out_stamp_o,
    .out_count_o,
    .drop_total_o
  );

endmodule
